@@ hw/rtl/ssc_pkg.sv @@
// Types, constants and helper functions of the stroke sequence controller.
package ssc_pkg;

    localparam int MAX_MOVES_DEF = 16;
    localparam int MOVE_W        = 5;
    localparam int TICK_W        = 16;
    localparam int DELAY_W       = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 24;

    localparam logic [TICK_W-1:0]  FRAME_TTL       = 16'd2000;
    localparam logic [TICK_W-1:0]  TICKS_PER_SEC   = 16'd1000;
    localparam logic [DELAY_W-1:0] DELAY_UNIT      = 12'd10;
    localparam logic [6:0]         TIMEOUT_MAX_SEC = 7'd65;
    localparam logic [6:0]         TIMEOUT_RST_SEC = 7'd30;

    typedef enum logic [2:0] {
        PH_END       = 3'd0,
        PH_START     = 3'd1,
        PH_FWD_RET   = 3'd2,
        PH_BWD_RET   = 3'd3,
        PH_FWD_READY = 3'd4,
        PH_BWD_READY = 3'd5,
        PH_GO_FWD    = 3'd6,
        PH_GO_BWD    = 3'd7
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION_CONTROL = 3'd0,
        CFG_PREFERRED_SIDE    = 3'd1,
        CFG_STROKE_DELAY      = 3'd2,
        CFG_STROKE_COUNT      = 3'd3,
        CFG_STROKE_TIMEOUT    = 3'd4,
        CFG_BLADE_RECIPE      = 3'd5,
        CFG_FRAME_RECIPE      = 3'd6,
        CFG_SPEED_RECIPE      = 3'd7
    } t_cfg_idx;

    // Events of one sequence step, passed from the phase logic to the datapath.
    typedef struct packed {
        logic tick_clr;
        logic fwd_ready;
        logic bwd_ready;
        logic ret;
        logic start_move;
        logic ret_go;
        logic arrive;
        logic finish;
        logic pos_alarm;
        logic frame_alarm;
        logic time_alarm;
    } t_seq_ev;

    // Even moves use the low byte, odd moves the high byte; moves 16 and up read 0.
    function automatic logic recipe_bit(input logic [15:0] recipe,
                                        input logic [MOVE_W-1:0] m);
        logic [7:0] half;
        half = m[0] ? recipe[15:8] : recipe[7:0];
        if (m[4]) begin
            return 1'b0;
        end
        return half[m[3:1]];
    endfunction

endpackage

@@ hw/rtl/stroke_sequence_controller.sv @@
// Stroke sequence controller: eight-phase back-and-forth stroke sequencer, one tick per transfer.
//
// Each input transfer is one 1 ms tick carrying the limit switches, the move-complete flag,
// the frame sensors and the move-counter clear. The block takes one tick per clock cycle while
// its output register is empty or being drained, and returns one result per tick in the cycle
// after it is taken, from the single registered state update of phase, tick counter, move
// counter and drive registers. The result sits in an output register, and a new tick is taken
// in the same cycle the waiting result is transferred. Configuration must be written through
// the plain write port only while no tick is in flight; the block itself does not enforce this.
module stroke_sequence_controller
    import ssc_pkg::*;
#(
    parameter int MAX_MOVES = MAX_MOVES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [0] forward_limit, [1] backward_limit, [2] move_done, [3] frame_up_sensor,
    // [4] frame_down_sensor, [5] clear_moves, [7:6] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [2:0] phase, [3] side_a_valve, [4] side_b_valve, [5] frame_valve_out,
    // [6] speed_select, [7] forward_request, [8] backward_request, [9] position_alarm,
    // [10] frame_alarm, [11] timeout_alarm, [16:12] move_number, [23:17] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int LIM_CLOG = $clog2(MAX_MOVES + 1);
    localparam int LIM_W    = (LIM_CLOG > MOVE_W) ? LIM_CLOG : MOVE_W;
    localparam logic [LIM_W-1:0] MAX_MOVES_L = LIM_W'(MAX_MOVES);

    // configuration
    logic              r_dir_ctrl;
    logic              r_pref_side;
    logic [7:0]        r_delay;
    logic [MOVE_W-1:0] r_count;
    logic [6:0]        r_timeout;
    logic [15:0]       r_blade_rcp;
    logic [15:0]       r_frame_rcp;
    logic [15:0]       r_speed_rcp;

    // sequence state
    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic              r_ret, n_ret;
    logic [MOVE_W-1:0] r_move_cnt, n_move_cnt;
    logic              r_valve_a, n_valve_a;
    logic              r_valve_b, n_valve_b;
    logic              r_valve_f, n_valve_f;
    logic              r_req_fwd, n_req_fwd;
    logic              r_req_bwd, n_req_bwd;
    logic              r_speed, n_speed;

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    t_seq_ev           w_ev;
    logic              w_in_xfer;
    logic              w_fl, w_bl, w_done, w_fhi, w_flo, w_clr;
    logic              w_frame_ok, w_fwd_side;
    logic [DELAY_W-1:0] w_delay;
    logic [6:0]        w_tmo_sec;
    logic [TICK_W-1:0] w_tmo_ticks;
    logic [LIM_W-1:0]  w_limit;
    logic [MOVE_W-1:0] w_cnt_after;
    logic [MOVE_W-1:0] w_cnt_seq;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_fl   = i_s_axis_tdata[0];
    assign w_bl   = i_s_axis_tdata[1];
    assign w_done = i_s_axis_tdata[2];
    assign w_fhi  = i_s_axis_tdata[3];
    assign w_flo  = i_s_axis_tdata[4];
    assign w_clr  = i_s_axis_tdata[5];

    assign w_delay     = DELAY_W'(r_delay) * DELAY_UNIT;
    assign w_tmo_sec   = (r_timeout > TIMEOUT_MAX_SEC) ? TIMEOUT_MAX_SEC : r_timeout;
    assign w_tmo_ticks = TICK_W'(w_tmo_sec) * TICKS_PER_SEC;
    assign w_limit     = (LIM_W'(r_count) > MAX_MOVES_L) ? MAX_MOVES_L : LIM_W'(r_count);
    assign w_frame_ok  = (r_valve_f == w_flo) && (r_valve_f != w_fhi);
    assign w_fwd_side  = (r_phase == PH_GO_FWD);
    // a return stroke does not count as a move
    assign w_cnt_after = r_ret ? r_move_cnt : r_move_cnt + MOVE_W'(1);

    // next phase and step events
    always_comb begin
        n_phase = r_phase;
        w_ev    = '0;
        case (r_phase)
            PH_END: begin
                w_ev.tick_clr = 1'b1;
                n_phase       = PH_START;
            end
            PH_START: begin
                if (w_fl ^ w_bl) begin
                    w_ev.tick_clr = 1'b1;
                    if (r_dir_ctrl && r_pref_side && !w_fl) begin
                        w_ev.ret = 1'b1;
                        n_phase  = PH_BWD_RET;
                    end else if (r_dir_ctrl && !r_pref_side && w_fl) begin
                        w_ev.ret = 1'b1;
                        n_phase  = PH_FWD_RET;
                    end else if (w_fl) begin
                        w_ev.fwd_ready = 1'b1;
                        n_phase        = PH_FWD_READY;
                    end else begin
                        w_ev.bwd_ready = 1'b1;
                        n_phase        = PH_BWD_READY;
                    end
                end else begin
                    w_ev.pos_alarm = 1'b1;
                    n_phase        = PH_END;
                end
            end
            PH_FWD_READY, PH_BWD_READY: begin
                if (r_tick > TICK_W'(w_delay)) begin
                    if (w_frame_ok) begin
                        w_ev.start_move = 1'b1;
                        w_ev.tick_clr   = 1'b1;
                        n_phase = (r_phase == PH_FWD_READY) ? PH_GO_BWD : PH_GO_FWD;
                    end else if (r_tick > FRAME_TTL) begin
                        w_ev.frame_alarm = 1'b1;
                        n_phase          = PH_END;
                    end
                end
            end
            PH_GO_FWD, PH_GO_BWD: begin
                if (w_done && (w_fl == w_fwd_side) && (w_bl == !w_fwd_side)) begin
                    w_ev.arrive = 1'b1;
                    if (LIM_W'(w_cnt_after) < w_limit) begin
                        w_ev.tick_clr  = 1'b1;
                        w_ev.fwd_ready = w_fwd_side;
                        w_ev.bwd_ready = !w_fwd_side;
                        n_phase        = w_fwd_side ? PH_FWD_READY : PH_BWD_READY;
                    end else begin
                        w_ev.finish = 1'b1;
                        n_phase     = PH_END;
                    end
                end else begin
                    if (r_tick > w_tmo_ticks) begin
                        w_ev.time_alarm = 1'b1;
                        n_phase         = PH_END;
                    end
                    if ((r_tick > FRAME_TTL) && w_done) begin
                        w_ev.pos_alarm = 1'b1;
                        n_phase        = PH_END;
                    end
                end
            end
            PH_FWD_RET, PH_BWD_RET: begin
                if (w_fhi && !w_flo) begin
                    w_ev.ret_go   = 1'b1;
                    w_ev.tick_clr = 1'b1;
                    n_phase = (r_phase == PH_BWD_RET) ? PH_GO_FWD : PH_GO_BWD;
                end else if (r_tick > FRAME_TTL) begin
                    w_ev.frame_alarm = 1'b1;
                    n_phase          = PH_END;
                end
            end
            default: begin
                n_phase = PH_END;
            end
        endcase
    end

    // datapath updates driven by the step events
    always_comb begin
        n_valve_a = r_valve_a;
        n_valve_b = r_valve_b;
        n_valve_f = r_valve_f;
        n_req_fwd = r_req_fwd;
        n_req_bwd = r_req_bwd;
        n_speed   = r_speed;

        if (w_ev.finish) begin
            w_cnt_seq = '0;
        end else if (w_ev.arrive) begin
            w_cnt_seq = w_cnt_after;
        end else begin
            w_cnt_seq = r_move_cnt;
        end
        n_move_cnt = w_clr ? '0 : w_cnt_seq;

        if (w_ev.ret) begin
            n_ret = 1'b1;
        end else if (w_ev.fwd_ready || w_ev.bwd_ready || w_ev.arrive) begin
            n_ret = 1'b0;
        end else begin
            n_ret = r_ret;
        end

        if (w_ev.fwd_ready) begin
            n_valve_a = 1'b0;
            n_valve_b = recipe_bit(r_blade_rcp, w_cnt_seq);
            n_valve_f = recipe_bit(r_frame_rcp, w_cnt_seq);
        end
        if (w_ev.bwd_ready) begin
            n_valve_b = 1'b0;
            n_valve_a = recipe_bit(r_blade_rcp, w_cnt_seq);
            n_valve_f = recipe_bit(r_frame_rcp, w_cnt_seq);
        end
        if (w_ev.ret) begin
            n_valve_a = 1'b0;
            n_valve_b = 1'b0;
            n_valve_f = 1'b0;
        end
        if (w_ev.finish) begin
            n_valve_f = 1'b0;
        end

        if (w_ev.start_move) begin
            n_speed = recipe_bit(r_speed_rcp, r_move_cnt);
            if (r_phase == PH_FWD_READY) begin
                n_req_bwd = 1'b1;
            end else begin
                n_req_fwd = 1'b1;
            end
        end
        if (w_ev.ret_go) begin
            n_speed = 1'b0;
            if (r_phase == PH_BWD_RET) begin
                n_req_fwd = 1'b1;
            end else begin
                n_req_bwd = 1'b1;
            end
        end
        // drop the active request on arrival or while the drive reports not done
        if ((r_phase == PH_GO_FWD || r_phase == PH_GO_BWD) && (w_ev.arrive || !w_done)) begin
            if (w_fwd_side) begin
                n_req_fwd = 1'b0;
            end else begin
                n_req_bwd = 1'b0;
            end
        end

        n_tick = (w_ev.tick_clr ? '0 : r_tick) + TICK_W'(1);

        n_out_data = {7'd0, n_move_cnt, w_ev.time_alarm, w_ev.frame_alarm, w_ev.pos_alarm,
                      n_req_bwd, n_req_fwd, n_speed, n_valve_f, n_valve_b, n_valve_a,
                      n_phase};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_ctrl  <= 1'b0;
            r_pref_side <= 1'b0;
            r_delay     <= '0;
            r_count     <= '0;
            r_timeout   <= TIMEOUT_RST_SEC;
            r_blade_rcp <= '0;
            r_frame_rcp <= '0;
            r_speed_rcp <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DIRECTION_CONTROL: r_dir_ctrl  <= i_cfg_wdata[0];
                CFG_PREFERRED_SIDE:    r_pref_side <= i_cfg_wdata[0];
                CFG_STROKE_DELAY:      r_delay     <= i_cfg_wdata[7:0];
                CFG_STROKE_COUNT:      r_count     <= i_cfg_wdata[MOVE_W-1:0];
                CFG_STROKE_TIMEOUT:    r_timeout   <= i_cfg_wdata[6:0];
                CFG_BLADE_RECIPE:      r_blade_rcp <= i_cfg_wdata;
                CFG_FRAME_RECIPE:      r_frame_rcp <= i_cfg_wdata;
                CFG_SPEED_RECIPE:      r_speed_rcp <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_END;
            r_tick      <= '0;
            r_ret       <= 1'b0;
            r_move_cnt  <= '0;
            r_valve_a   <= 1'b0;
            r_valve_b   <= 1'b0;
            r_valve_f   <= 1'b0;
            r_req_fwd   <= 1'b0;
            r_req_bwd   <= 1'b0;
            r_speed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_ret       <= n_ret;
                r_move_cnt  <= n_move_cnt;
                r_valve_a   <= n_valve_a;
                r_valve_b   <= n_valve_b;
                r_valve_f   <= n_valve_f;
                r_req_fwd   <= n_req_fwd;
                r_req_bwd   <= n_req_bwd;
                r_speed     <= n_speed;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

    // any alarm in a result goes with the end phase
    a_alarm_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[9] || r_out_data[10] || r_out_data[11]))
            |-> (r_out_data[2:0] == PH_END))
        else $error("alarm reported outside the end phase");

    // the end phase always restarts on the next tick
    a_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && r_phase == PH_END) |=> (r_phase == PH_START))
        else $error("end phase did not advance to start");

    // the two blade valves are never driven together
    a_blade_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_valve_a && r_valve_b))
        else $error("both blade valves on");

    // the move counter stays within the move limit
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LIM_W'(r_move_cnt) <= MAX_MOVES_L)
        else $error("move counter beyond MAX_MOVES");

endmodule
